// File: sv/rs_parity_encoder_gf256_defines.svh
// Assertion macros for the checker file of the parity encoder.
`ifndef RS_PARITY_ENCODER_GF256_DEFINES_SVH
`define RS_PARITY_ENCODER_GF256_DEFINES_SVH

// Checks a property on every rising edge of aclk while aresetn is high.
`define RSPE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks a property on every rising edge of aclk, reset included.
`define RSPE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: sv/rspe_pkg.sv
package rspe_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W = 6;
    localparam int RESET_PARITY = 10;
    localparam logic [BYTE_W-1:0] POLY_LOW = 8'h1D;
    localparam logic [BYTE_W-1:0] GF_ONE = 8'h01;

    typedef struct packed {
        logic coef_clr;
        logic build;
        logic rem_clr;
        logic step;
        logic last;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] a);
        return {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? POLY_LOW : '0);
    endfunction

    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] x;
        acc = '0;
        x = a;
        for (int k = 0; k < BYTE_W; k++) begin
            if (b[k]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

endpackage

// File: sv/rspe_cell.sv
module rspe_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rspe_pkg::cell_ctrl_t            ctrl,
    input  logic [rspe_pkg::BYTE_W-1:0]     fb,
    input  logic [rspe_pkg::BYTE_W-1:0]     root,
    input  logic [rspe_pkg::BYTE_W-1:0]     rem_right,
    input  logic [rspe_pkg::BYTE_W-1:0]     coef_left,
    input  logic [rspe_pkg::BYTE_W-1:0]     out_right,
    output logic [rspe_pkg::BYTE_W-1:0]     rem_q,
    output logic [rspe_pkg::BYTE_W-1:0]     coef_q,
    output logic [rspe_pkg::BYTE_W-1:0]     out_q
);

    logic [rspe_pkg::BYTE_W-1:0] rem_reg, rem_next;
    logic [rspe_pkg::BYTE_W-1:0] coef_reg, coef_next;
    logic [rspe_pkg::BYTE_W-1:0] out_reg, out_next;
    logic [rspe_pkg::BYTE_W-1:0] mul_a, mul_b, prod, folded;

    // One multiplier serves both the generator build and the byte fold.
    assign mul_a = ctrl.build ? coef_left : coef_reg;
    assign mul_b = ctrl.build ? root : fb;
    assign prod = rspe_pkg::gf_mul(mul_a, mul_b);
    assign folded = rem_right ^ prod;

    always_comb begin
        rem_next = rem_reg;
        if (ctrl.rem_clr) begin
            rem_next = '0;
        end else if (ctrl.step) begin
            rem_next = ctrl.last ? '0 : folded;
        end
    end

    always_comb begin
        coef_next = coef_reg;
        if (ctrl.coef_clr) begin
            coef_next = '0;
        end else if (ctrl.build) begin
            coef_next = coef_reg ^ prod;
        end
    end

    always_comb begin
        out_next = out_reg;
        if (ctrl.step && ctrl.last) begin
            out_next = folded;
        end else if (ctrl.shift) begin
            out_next = out_right;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            coef_reg <= '0;
        end else begin
            rem_reg <= rem_next;
            coef_reg <= coef_next;
        end
        out_reg <= out_next;
    end

    assign rem_q = rem_reg;
    assign coef_q = coef_reg;
    assign out_q = out_reg;

endmodule

// File: sv/rs_parity_encoder_gf256.sv
// Latency: the first parity byte of a block is offered the cycle after its last data byte.
// Throughput: one data byte per cycle outside a generator build and one parity byte per cycle while m_ready
// is high; a last byte waits while the parity of the previous block is still draining.
// Reset (which sets 10 parity bytes) and each parity-count write on cfg_data rebuild the generator;
// during the build no item or register write is accepted.
module rs_parity_encoder_gf256 #(
    parameter int MAX_PARITY = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rspe_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rspe_pkg::BYTE_W-1:0]     s_data_byte,
    input  logic                            s_last_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rspe_pkg::BYTE_W-1:0]     m_parity_byte,
    output logic                            m_last_parity
);

    localparam int CNT_W = $clog2(MAX_PARITY + 1);
    localparam int CMP_W = (CNT_W > rspe_pkg::CFG_W) ? CNT_W : rspe_pkg::CFG_W;
    localparam logic [CNT_W-1:0] RST_CNT = CNT_W'((rspe_pkg::RESET_PARITY > MAX_PARITY) ?
                                                  MAX_PARITY : rspe_pkg::RESET_PARITY);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] build_cnt_reg, build_cnt_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [rspe_pkg::BYTE_W-1:0] root_reg, root_next;
    logic [CMP_W-1:0] cfg_ext;
    logic [CNT_W-1:0] cfg_eff;
    logic building, out_free, cfg_fire, s_fire, m_fire;
    logic [rspe_pkg::BYTE_W-1:0] fb;
    rspe_pkg::cell_ctrl_t ctrl;

    logic [rspe_pkg::BYTE_W-1:0] rem_q [MAX_PARITY];
    logic [rspe_pkg::BYTE_W-1:0] coef_q [MAX_PARITY];
    logic [rspe_pkg::BYTE_W-1:0] out_q [MAX_PARITY];

    assign building = (build_cnt_reg != '0);
    assign out_free = (out_cnt_reg == '0) || ((out_cnt_reg == CNT_ONE) && m_ready);

    assign cfg_ready = !building;
    assign s_ready = !building && (!s_last_data || out_free);
    assign m_valid = (out_cnt_reg != '0);
    assign m_parity_byte = out_q[0];
    assign m_last_parity = (out_cnt_reg == CNT_ONE);

    assign cfg_fire = cfg_valid && cfg_ready;
    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    assign cfg_ext = CMP_W'(cfg_data);
    assign cfg_eff = (cfg_ext == '0) ? CNT_ONE :
                     (cfg_ext > CMP_W'(MAX_PARITY)) ? CNT_W'(MAX_PARITY) : CNT_W'(cfg_ext);

    assign fb = s_data_byte ^ rem_q[0];

    always_comb begin
        ctrl.coef_clr = cfg_fire;
        ctrl.build = building;
        ctrl.rem_clr = cfg_fire;
        ctrl.step = s_fire;
        ctrl.last = s_last_data;
        ctrl.shift = m_fire;
    end

    always_comb begin
        count_next = count_reg;
        build_cnt_next = build_cnt_reg;
        root_next = root_reg;
        if (cfg_fire) begin
            count_next = cfg_eff;
            build_cnt_next = cfg_eff;
            root_next = rspe_pkg::GF_ONE;
        end else if (building) begin
            build_cnt_next = build_cnt_reg - CNT_ONE;
            root_next = rspe_pkg::gf_xtime(root_reg);
        end
    end

    always_comb begin
        out_cnt_next = out_cnt_reg;
        if (s_fire && s_last_data) begin
            out_cnt_next = count_reg;
        end else if (m_fire) begin
            out_cnt_next = out_cnt_reg - CNT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= RST_CNT;
            build_cnt_reg <= RST_CNT;
            root_reg <= rspe_pkg::GF_ONE;
            out_cnt_reg <= '0;
        end else begin
            count_reg <= count_next;
            build_cnt_reg <= build_cnt_next;
            root_reg <= root_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

    for (genvar i = 0; i < MAX_PARITY; i++) begin : g_cell
        logic [rspe_pkg::BYTE_W-1:0] rem_right, coef_left, out_right;

        if (i == MAX_PARITY - 1) begin : g_tail
            assign rem_right = '0;
            assign out_right = '0;
        end else begin : g_mid
            assign rem_right = rem_q[i+1];
            assign out_right = out_q[i+1];
        end

        if (i == 0) begin : g_head
            assign coef_left = rspe_pkg::GF_ONE;
        end else begin : g_body
            assign coef_left = coef_q[i-1];
        end

        rspe_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .fb        (fb),
            .root      (root_reg),
            .rem_right (rem_right),
            .coef_left (coef_left),
            .out_right (out_right),
            .rem_q     (rem_q[i]),
            .coef_q    (coef_q[i]),
            .out_q     (out_q[i])
        );
    end

endmodule

// File: sv/rspe_checker.sv
`include "rs_parity_encoder_gf256_defines.svh"

module rspe_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [rspe_pkg::BYTE_W-1:0]  m_parity_byte,
    input logic                         m_last_parity
);

    // A stalled parity item holds its value.
    `RSPE_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_parity_byte) && $stable(m_last_parity), "stalled parity item changed")

    // A block's parity run continues until its last byte.
    `RSPE_ASSERT(a_run_cont, m_valid && m_ready && !m_last_parity |=> m_valid, "parity run broke off before its last byte")

    // Reset leaves no parity pending.
    `RSPE_ASSERT_RST(a_rst_out, !aresetn |=> !m_valid, "parity offered right after reset")

    // Reset starts a generator build, so nothing is taken in the next cycle.
    `RSPE_ASSERT_RST(a_rst_build, !aresetn |=> !s_ready && !cfg_ready, "item taken during generator build")

    // A register write starts a generator build.
    `RSPE_ASSERT(a_cfg_build, cfg_valid && cfg_ready |=> !s_ready && !cfg_ready, "no generator build after register write")

endmodule

bind rs_parity_encoder_gf256 rspe_checker u_rspe_checker (.*);
